// File: hdl/rrs_pkg.sv
package rrs_pkg;

    localparam int MAX_TASKS = 16;

    typedef enum logic [2:0] {
        CFG_TASK_COUNT  = 3'd0,
        CFG_QUANTUM     = 3'd1,
        CFG_TOTAL_TICKS = 3'd2
    } t_cfg_idx;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        DP_NONE   = 3'd0,
        DP_LOAD   = 3'd1,
        DP_START  = 3'd2,
        DP_CHARGE = 3'd3,
        DP_SCAN   = 3'd4,
        DP_SETTLE = 3'd5
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   scan_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
    } t_dp_sts;

endpackage

// File: hdl/rrs_ram.sv
module rrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hdl/rrs_ctrl.sv
module rrs_ctrl
    import rrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_op,
    input  t_dp_sts i_sts,
    input  logic    i_tick_ok,
    input  logic    i_first,
    input  logic    i_out_busy,
    output logic    o_ready,
    output t_dp_cmd o_cmd,
    output logic    o_emit
);
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_CHARGE = 6'b000100,
        S_SCAN   = 6'b001000,
        S_SETTLE = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_first_scan, n_first_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_first_scan <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_scan <= n_first_scan;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_first_scan = r_first_scan;
        o_ready      = 1'b0;
        o_emit       = 1'b0;
        o_cmd.op     = DP_NONE;
        o_cmd.scan_zero = r_first_scan;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.op = DP_LOAD;
                    end else if (i_tick_ok) begin
                        if (i_first) begin
                            n_state      = S_SCAN;
                            n_first_scan = 1'b1;
                            o_cmd.op     = DP_START;
                        end else begin
                            n_state  = S_CHARGE;
                            o_cmd.op = DP_START;
                        end
                    end
                end
            end
            S_CHARGE: begin
                o_cmd.op     = DP_CHARGE;
                n_first_scan = 1'b0;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = DP_SCAN;
                if (i_sts.scan_last) begin
                    n_state = r_first_scan ? S_START : S_SETTLE;
                end
            end
            S_START: begin
                o_cmd.op = DP_SETTLE;
                o_cmd.scan_zero = 1'b1;
                n_state  = S_CHARGE;
            end
            S_SETTLE: begin
                o_cmd.op = DP_SETTLE;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> !i_out_busy) else $error("emit into busy output");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_emit_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> r_state == S_IDLE) else $error("emit not back to idle");
`endif
endmodule

// File: hdl/rrs_dp.sv
module rrs_dp
    import rrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [3:0]  i_task_index,
    input  logic [15:0] i_arrival_time,
    input  logic [15:0] i_burst_time,
    input  logic [4:0]  i_task_count,
    input  logic [7:0]  i_quantum,
    output t_dp_sts     o_sts,
    output logic [3:0]  o_running_task,
    output logic        o_running_valid,
    output logic        o_switched,
    output logic [4:0]  o_ready_count,
    output logic [15:0] o_switch_total,
    output logic [31:0] o_waiting_sum,
    output logic [31:0] o_turnaround_sum,
    output logic [15:0] o_tick_now
);
    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [15:0] r_bur [MAX_TASKS];
    logic [15:0] r_srv [MAX_TASKS];
    logic [IW-1:0] r_ring [MAX_TASKS];
    logic [IW-1:0] r_head, r_cur, r_scan;
    logic [CW-1:0] r_cnt;
    logic          r_cv, r_sw;
    logic [7:0]    r_slice;
    logic [15:0]   r_tick, r_swc;
    logic [31:0]   r_wait, r_turn;

    logic [CW:0]   w_inuse;
    logic [IW-1:0] w_tail, w_h1, w_h2, w_pop0, w_pop1, w_arr_ra;
    logic [7:0]    w_q;
    logic [15:0]   w_when, w_arr_q;
    logic          w_fin0, w_pre, w_push, w_fin1, w_hit;
    logic [IW-1:0] w_t1;
    logic [CW-1:0] w_c1, w_c2;
    logic [32:0]   w_ws, w_ts;

    assign w_arr_ra = (i_cmd.op == DP_SCAN) ? IW'(r_scan + 1'b1) : '0;

    rrs_ram #(.WIDTH(16), .DEPTH(MAX_TASKS)) u_arr (
        .i_clk(i_clk), .i_we(i_cmd.op == DP_LOAD), .i_waddr(IW'(i_task_index)),
        .i_wdata(i_arrival_time), .i_raddr(w_arr_ra), .o_rdata(w_arr_q)
    );

    assign w_inuse = ({1'b0, i_task_count} > (CW+1)'(MAX_TASKS)) ? (CW+1)'(MAX_TASKS)
                   : (CW+1)'(i_task_count);
    assign w_tail  = IW'(r_head + IW'(r_cnt));
    assign w_q     = (i_quantum == 8'd0) ? 8'd1 : i_quantum;
    assign w_when  = i_cmd.scan_zero ? 16'd0 : r_tick;
    assign w_hit   = ({1'b0, r_scan} < w_inuse[IW:0]) && (w_arr_q == w_when);
    assign o_sts.scan_last = (r_scan == IW'(MAX_TASKS - 1));

    assign w_pop0 = r_ring[r_head];
    assign w_h1   = IW'(r_head + 1'b1);
    assign w_pre  = r_cv && (r_slice >= w_q) && (r_cnt != '0);
    assign w_fin0 = r_srv[r_cur] < r_bur[r_cur];
    assign w_push = w_pre && w_fin0 && (r_cnt < CW'(MAX_TASKS));
    always_comb begin
        w_c1 = r_cnt;
        w_t1 = r_cur;
        if (w_pre) begin
            w_t1 = w_pop0;
            if (!w_push) w_c1 = CW'(r_cnt - 1'b1);
        end
    end
    assign w_h2   = w_pre ? w_h1 : r_head;
    assign w_pop1 = (w_push && (w_h2 == w_tail)) ? r_cur : r_ring[w_h2];
    assign w_fin1 = r_cv && (r_srv[w_t1] >= r_bur[w_t1]);
    assign w_c2   = w_c1;
    assign w_ws   = {1'b0, r_wait} + 33'(r_cnt);
    assign w_ts   = {1'b0, r_turn} + 33'(r_cnt) + 33'(r_cv);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_bur[IW'(i_task_index)] <= i_burst_time;
            end
            default: ;
        endcase
        if (i_cmd.op == DP_SCAN && w_hit && r_cnt < CW'(MAX_TASKS)) begin
            r_ring[w_tail] <= r_scan;
        end
        if (i_cmd.op == DP_SETTLE && w_push) begin
            r_ring[w_tail] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TASKS; k++) r_srv[k] <= '0;
            r_head <= '0; r_cnt <= '0; r_cur <= '0; r_cv <= 1'b0; r_sw <= 1'b0;
            r_slice <= '0; r_tick <= '0; r_swc <= '0; r_wait <= '0; r_turn <= '0;
            r_scan <= '0;
        end else begin
            case (i_cmd.op)
                DP_LOAD: r_srv[IW'(i_task_index)] <= '0;
                DP_START: begin
                    r_scan <= '0;
                    r_sw   <= 1'b0;
                end
                DP_CHARGE: begin
                    r_tick <= r_tick + 16'd1;
                    if (r_cv) begin
                        if (r_srv[r_cur] != 16'hFFFF) r_srv[r_cur] <= r_srv[r_cur] + 16'd1;
                        if (r_slice != 8'hFF) r_slice <= r_slice + 8'd1;
                    end
                    r_wait <= w_ws[32] ? 32'hFFFF_FFFF : w_ws[31:0];
                    r_turn <= w_ts[32] ? 32'hFFFF_FFFF : w_ts[31:0];
                    r_scan <= '0;
                end
                DP_SCAN: begin
                    r_scan <= IW'(r_scan + 1'b1);
                    if (w_hit && r_cnt < CW'(MAX_TASKS)) r_cnt <= CW'(r_cnt + 1'b1);
                end
                DP_SETTLE: begin
                    if (i_cmd.scan_zero) begin
                        if (r_cnt != '0) begin
                            r_cur <= w_pop0; r_cv <= 1'b1; r_slice <= '0;
                            r_head <= w_h1; r_cnt <= CW'(r_cnt - 1'b1);
                        end
                    end else begin
                        logic [IW-1:0] h;
                        logic [CW-1:0] c;
                        logic [15:0]   s;
                        logic          any;
                        h = w_h2;
                        c = w_c2;
                        s = r_swc;
                        any = w_pre;
                        if (w_pre) begin
                            r_slice <= '0;
                            if (s != 16'hFFFF) s = s + 16'd1;
                        end
                        if (w_fin1) begin
                            r_slice <= '0;
                            if (c != '0) begin
                                any = 1'b1;
                                if (s != 16'hFFFF) s = s + 16'd1;
                                r_cur <= w_pop1;
                                h = IW'(h + 1'b1);
                                c = CW'(c - 1'b1);
                                r_cv <= 1'b1;
                            end else begin
                                r_cv <= 1'b0; r_cur <= '0;
                            end
                        end else if (!r_cv) begin
                            if (c != '0) begin
                                r_cur <= w_pop1; r_cv <= 1'b1; r_slice <= '0;
                                h = IW'(h + 1'b1);
                                c = CW'(c - 1'b1);
                            end
                        end else begin
                            r_cur <= w_t1;
                        end
                        r_head <= h; r_cnt <= c; r_swc <= s; r_sw <= any;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_running_task   = r_cv ? 4'(r_cur) : 4'd0;
    assign o_running_valid  = r_cv;
    assign o_switched       = r_sw;
    assign o_ready_count    = 5'(r_cnt);
    assign o_switch_total   = r_swc;
    assign o_waiting_sum    = r_wait;
    assign o_turnaround_sum = r_turn;
    assign o_tick_now       = r_tick;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_TASKS)) else $error("ready count overflow");
    a_wait_le_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait <= r_turn) else $error("waiting sum above turnaround");
    a_swc_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_swc >= $past(r_swc)) else $error("switch count decreased");
`endif
endmodule

// File: hdl/round_robin_cpu_scheduler_core.sv
// channel | dir | handshake             | payload
// in      | in  | i_valid / o_ready     | op, task_index, arrival_time, burst_time
// cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// out     | out | o_valid / i_ready     | running_task .. turnaround_sum
// A load is stored from idle. A tick runs charge, arrival scan (one entry per cycle),
// settle and emit; the first tick scans twice, with a settle before the charge.
// Reset: synchronous, active low; clears served counts and all counters.
// A result waits in the output register; a new item is taken while it waits,
// and the next tick stalls only at its result until the output is free.
module round_robin_cpu_scheduler_core
    import rrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [3:0]  i_task_index,
    input  logic [15:0] i_arrival_time,
    input  logic [15:0] i_burst_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_running_task,
    output logic        o_running_valid,
    output logic        o_switched,
    output logic [4:0]  o_ready_count,
    output logic [15:0] o_switch_total,
    output logic [31:0] o_waiting_sum,
    output logic [31:0] o_turnaround_sum
);
    logic [4:0]  r_task_count;
    logic [7:0]  r_quantum;
    logic [15:0] r_total;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic        w_emit, r_ov;
    logic [3:0]  w_rt;
    logic        w_rv, w_sw;
    logic [4:0]  w_rc;
    logic [15:0] w_st, w_tick;
    logic [31:0] w_ws, w_ts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= 5'd1;
            r_quantum    <= 8'd2;
            r_total      <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                2'(CFG_TASK_COUNT):  r_task_count <= i_cfg_data[4:0];
                2'(CFG_QUANTUM):     r_quantum    <= i_cfg_data[7:0];
                2'(CFG_TOTAL_TICKS): r_total      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rrs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_op(i_op),
        .i_sts(w_sts), .i_tick_ok(w_tick < r_total), .i_first(w_tick == 16'd0),
        .i_out_busy(r_ov && !i_ready), .o_ready(o_ready), .o_cmd(w_cmd),
        .o_emit(w_emit)
    );

    rrs_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_task_index(i_task_index), .i_arrival_time(i_arrival_time),
        .i_burst_time(i_burst_time), .i_task_count(r_task_count),
        .i_quantum(r_quantum), .o_sts(w_sts), .o_running_task(w_rt),
        .o_running_valid(w_rv), .o_switched(w_sw), .o_ready_count(w_rc),
        .o_switch_total(w_st), .o_waiting_sum(w_ws), .o_turnaround_sum(w_ts),
        .o_tick_now(w_tick)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_running_task   <= w_rt;
            o_running_valid  <= w_rv;
            o_switched       <= w_sw;
            o_ready_count    <= w_rc;
            o_switch_total   <= w_st;
            o_waiting_sum    <= w_ws;
            o_turnaround_sum <= w_ts;
        end
    end
    assign o_valid = r_ov;
endmodule
